// ----- hdl/alc_pkg.sv -----
// Shared types and constants for the approximate limit counter
`timescale 1ns / 1ps

package alc_pkg;

   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   localparam logic REG_GLOBAL_LIMIT   = 1'b0;
   localparam logic REG_CLIENTS_ONLINE = 1'b1;

   localparam logic [31:0] GLOBAL_LIMIT_RESET   = 32'h8000_0000;
   localparam logic [2:0]  CLIENTS_ONLINE_RESET = 3'd4;

   typedef struct packed {
      logic        op;
      logic [1:0]  client;
      logic [31:0] delta;
   } req_type;

   typedef struct packed {
      logic        accepted;
      logic [31:0] total;
   } rsp_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic rd_en;
      logic rd_sum;
      logic sum_acc;
      logic local_add;
      logic fold;
      logic head1;
      logic head2;
      logic apply_delta;
      logic div_step;
      logic hand1;
      logic hand2;
      logic rsp_load;
      logic rsp_ok;
      logic rsp_sum;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic req_op;
      logic req_in_range;
      logic fits_local;
      logic hr_lt_delta;
      logic sum_last;
      logic div_last;
   } status_type;

endpackage

// ----- hdl/alc_datapath.sv -----
// Datapath: client counter memory, global registers, headroom, divider, result register
`timescale 1ns / 1ps

module alc_datapath #(
   parameter int NUM_CLIENTS = 4,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  alc_pkg::req_type     req_payload,
   input  logic [31:0]          global_limit,
   input  logic [2:0]           clients_online,
   input  alc_pkg::cmd_type     cmd,
   output alc_pkg::status_type  status,
   output alc_pkg::rsp_type     rsp_payload
);
   import alc_pkg::*;

   localparam int EW    = (COUNT_WIDTH > 32) ? COUNT_WIDTH : 32;
   localparam int IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
   localparam int CNT_W = $clog2(COUNT_WIDTH + 1);
   localparam int CW    = COUNT_WIDTH;

   // one row holds {budget, count}
   logic [2*CW-1:0]      mem_ff [NUM_CLIENTS];
   logic [NUM_CLIENTS-1:0] valid_ff;

   logic [IDX_W-1:0] cl_ff, idx_ff, raddr;
   logic [31:0]      delta_ff;
   logic [CW-1:0]    gc_ff, gr_ff, acc_ff, t_ff, hr_ff, quo_ff, pre_ff;
   logic             under_ff;
   logic [2:0]       rem_ff;
   logic [CNT_W-1:0] div_cnt_ff;
   logic [CW-1:0]    rd_count_ff, rd_budget_ff;
   logic             rd_vld_ff;
   rsp_type          rsp_ff;

   logic [6:0]       client_ext;
   logic [EW-1:0]    limit_ext, delta_ext;
   logic [CW-1:0]    lim, delta_cw, cur_count, cur_budget, room, half, pre_in;
   logic [2:0]       divisor;
   logic [3:0]       trial, trial_diff;
   logic             trial_ge;
   logic             wr_en;
   logic [2*CW-1:0]  wr_data;
   logic [EW-1:0]    acc_ext;

   assign client_ext = {5'b0, req_payload.client};
   assign limit_ext  = EW'(global_limit);
   assign lim        = limit_ext[CW-1:0];
   assign delta_ext  = EW'(delta_ff);
   assign delta_cw   = delta_ext[CW-1:0];
   assign cur_count  = rd_vld_ff ? rd_count_ff : '0;
   assign cur_budget = rd_vld_ff ? rd_budget_ff : '0;
   assign room       = cur_budget - cur_count;
   assign divisor    = (clients_online == 3'd0) ? 3'd1 : clients_online;
   assign trial      = {rem_ff, quo_ff[CW-1]};
   assign trial_ge   = trial >= {1'b0, divisor};
   assign trial_diff = trial - {1'b0, divisor};
   assign half       = quo_ff >> 1;
   assign pre_in     = (half > gc_ff) ? gc_ff : half;
   assign raddr      = cmd.rd_sum ? idx_ff : cl_ff;
   assign acc_ext    = EW'(acc_ff);

   assign status.req_op       = req_payload.op;
   assign status.req_in_range = client_ext < 7'(NUM_CLIENTS);
   assign status.fits_local   = EW'(room) >= delta_ext;
   assign status.hr_lt_delta  = EW'(hr_ff) < delta_ext;
   assign status.sum_last     = idx_ff == IDX_W'(NUM_CLIENTS - 1);
   assign status.div_last     = div_cnt_ff == CNT_W'(COUNT_WIDTH - 1);

   assign rsp_payload = rsp_ff;

   always_comb begin
      wr_en   = cmd.local_add | cmd.fold | cmd.hand2;
      wr_data = '0;
      if (cmd.local_add) begin
         wr_data = {cur_budget, cur_count + delta_cw};
      end else if (cmd.hand2) begin
         wr_data = {quo_ff, pre_ff};
      end
   end

   // counter memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[cl_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         {rd_budget_ff, rd_count_ff} <= mem_ff[raddr];
         rd_vld_ff                   <= valid_ff[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         gc_ff    <= '0;
         gr_ff    <= '0;
      end else begin
         if (wr_en) begin
            valid_ff[cl_ff] <= 1'b1;
         end
         if (cmd.fold) begin
            gc_ff <= gc_ff + cur_count;
            gr_ff <= gr_ff - cur_budget;
         end else if (cmd.apply_delta) begin
            gc_ff <= gc_ff + delta_cw;
         end else if (cmd.hand1) begin
            gr_ff <= gr_ff + quo_ff;
         end else if (cmd.hand2) begin
            gc_ff <= gc_ff - pre_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cl_ff    <= client_ext[IDX_W-1:0];
         delta_ff <= req_payload.delta;
         acc_ff   <= gc_ff;
         idx_ff   <= '0;
      end
      if (cmd.sum_acc) begin
         acc_ff <= acc_ff + cur_count;
         idx_ff <= idx_ff + 1'b1;
      end
      if (cmd.head1) begin
         under_ff <= gc_ff > lim;
         t_ff     <= lim - gc_ff;
      end
      if (cmd.head2) begin
         hr_ff <= (under_ff || (gr_ff > t_ff)) ? '0 : t_ff - gr_ff;
      end
      if (cmd.apply_delta) begin
         quo_ff     <= hr_ff - delta_cw;
         rem_ff     <= '0;
         div_cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff     <= trial_ge ? trial_diff[2:0] : trial[2:0];
         quo_ff     <= {quo_ff[CW-2:0], trial_ge};
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
      if (cmd.hand1) begin
         pre_ff <= pre_in;
      end
      if (cmd.rsp_load) begin
         rsp_ff.accepted <= cmd.rsp_ok;
         rsp_ff.total    <= cmd.rsp_sum ? acc_ext[31:0] : 32'd0;
      end
   end

endmodule

// ----- hdl/alc_ctrl.sv -----
// Controller: sequences reads, fast path, fold back, headroom, divide and hand out
`timescale 1ns / 1ps

module alc_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  alc_pkg::status_type status,
   output alc_pkg::cmd_type    cmd
);
   import alc_pkg::*;

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b0000_0000_0001,
      ST_SUM_RD    = 12'b0000_0000_0010,
      ST_SUM_ACC   = 12'b0000_0000_0100,
      ST_ADD_RD    = 12'b0000_0000_1000,
      ST_ADD_CHK   = 12'b0000_0001_0000,
      ST_HEAD1     = 12'b0000_0010_0000,
      ST_HEAD2     = 12'b0000_0100_0000,
      ST_LIMIT_CHK = 12'b0000_1000_0000,
      ST_DIV       = 12'b0001_0000_0000,
      ST_HAND1     = 12'b0010_0000_0000,
      ST_HAND2     = 12'b0100_0000_0000,
      ST_RESP      = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      ok_ff, ok_in;
   logic      sum_ff, sum_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      ok_in        = ok_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      cmd          = '0;
      cmd.rsp_ok   = ok_ff;
      cmd.rsp_sum  = sum_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (status.req_op) begin
                  ok_in    = 1'b1;
                  sum_in   = 1'b1;
                  state_in = ST_SUM_RD;
               end else if (!status.req_in_range) begin
                  ok_in    = 1'b0;
                  sum_in   = 1'b0;
                  state_in = ST_RESP;
               end else begin
                  sum_in   = 1'b0;
                  state_in = ST_ADD_RD;
               end
            end
         end
         ST_SUM_RD: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sum = 1'b1;
            state_in   = ST_SUM_ACC;
         end
         ST_SUM_ACC: begin
            cmd.sum_acc = 1'b1;
            state_in    = status.sum_last ? ST_RESP : ST_SUM_RD;
         end
         ST_ADD_RD: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_ADD_CHK;
         end
         ST_ADD_CHK: begin
            if (status.fits_local) begin
               cmd.local_add = 1'b1;
               ok_in         = 1'b1;
               state_in      = ST_RESP;
            end else begin
               cmd.fold = 1'b1;
               state_in = ST_HEAD1;
            end
         end
         ST_HEAD1: begin
            cmd.head1 = 1'b1;
            state_in  = ST_HEAD2;
         end
         ST_HEAD2: begin
            cmd.head2 = 1'b1;
            state_in  = ST_LIMIT_CHK;
         end
         ST_LIMIT_CHK: begin
            if (status.hr_lt_delta) begin
               ok_in    = 1'b0;
               state_in = ST_RESP;
            end else begin
               cmd.apply_delta = 1'b1;
               state_in        = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_HAND1;
            end
         end
         ST_HAND1: begin
            cmd.hand1 = 1'b1;
            state_in  = ST_HAND2;
         end
         ST_HAND2: begin
            cmd.hand2 = 1'b1;
            ok_in     = 1'b1;
            state_in  = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.rsp_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         ok_ff        <= 1'b0;
         sum_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         ok_ff        <= ok_in;
         sum_ff       <= sum_in;
      end
   end

endmodule

// ----- hdl/approximate_limit_counter_top.sv -----
// Top level of the approximate limit counter: registers, controller and datapath
//
//  channel | direction | handshake              | payload
//  req     | in        | req_valid / req_ready  | req_payload (op, client, delta)
//  rsp     | out       | rsp_valid / rsp_ready  | rsp_payload (accepted, total)
//  csr     | in/out    | csr_psel / csr_penable | paddr, pwdata, prdata
//
// A read does one memory read and one add per client.
// An add on the fast path only updates the local count; the slow path folds back,
// checks headroom and runs the one-bit-a-cycle divider for the new budget.
// Synchronous reset clears all counts, budgets and the two registers to defaults.
// A new item is taken while the previous result waits; a stalled result holds
// the block in its final step until taken.
`timescale 1ns / 1ps

module approximate_limit_counter_top #(
   parameter int NUM_CLIENTS = 4,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  alc_pkg::req_type                req_payload,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output alc_pkg::rsp_type                rsp_payload,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [alc_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [alc_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [alc_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                            csr_pready
);
   import alc_pkg::*;

   logic [31:0] global_limit_ff;
   logic [2:0]  clients_online_ff;
   logic        csr_wr;
   logic        reg_idx;
   cmd_type     cmd;
   status_type  status;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign reg_idx    = csr_paddr[2];

   always_comb begin
      unique case (reg_idx)
         REG_GLOBAL_LIMIT:   csr_prdata = global_limit_ff;
         REG_CLIENTS_ONLINE: csr_prdata = {29'd0, clients_online_ff};
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         global_limit_ff   <= GLOBAL_LIMIT_RESET;
         clients_online_ff <= CLIENTS_ONLINE_RESET;
      end else if (csr_wr) begin
         unique case (reg_idx)
            REG_GLOBAL_LIMIT:   global_limit_ff   <= csr_pwdata;
            REG_CLIENTS_ONLINE: clients_online_ff <= csr_pwdata[2:0];
            default: ;
         endcase
      end
   end

   alc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   alc_datapath #(
      .NUM_CLIENTS (NUM_CLIENTS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_payload    (req_payload),
      .global_limit   (global_limit_ff),
      .clients_online (clients_online_ff),
      .cmd            (cmd),
      .status         (status),
      .rsp_payload    (rsp_payload)
   );

endmodule

// ----- bench/alc_tb_pkg.sv -----
// Request operation codes shared by the limit counter testbench and its checker
`timescale 1ns / 1ps

package alc_tb_pkg;

   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_READ = 1'b1;

endpackage

// ----- bench/approximate_limit_counter_checker.sv -----
// Checker for the limit counter: predicts each response and compares it
`timescale 1ns / 1ps

module approximate_limit_counter_checker #(
   parameter int NUM_CLIENTS = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  alc_pkg::req_type               req_payload,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  alc_pkg::rsp_type               rsp_payload,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [alc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [alc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic                           csr_pready,
   output int                             failures,
   output int                             pending
);
   import alc_pkg::*;
   import alc_tb_pkg::*;

   logic [31:0] limit_reg;
   logic [2:0]  online_reg;
   logic [31:0] client_count [NUM_CLIENTS];
   logic [31:0] client_budget [NUM_CLIENTS];
   logic [31:0] shared_count;
   logic [31:0] shared_reserve;
   rsp_type     due_rsp [$];

   function automatic logic [31:0] spare_room();
      if (shared_count > limit_reg)
         return 32'd0;
      if (shared_reserve > limit_reg - shared_count)
         return 32'd0;
      return limit_reg - shared_count - shared_reserve;
   endfunction

   function automatic rsp_type counter_step(req_type r);
      rsp_type     res;
      logic [31:0] sum;
      logic [31:0] divisor;
      logic [31:0] grant;
      logic [31:0] prefill;
      int          c;
      res = '0;
      c = r.client;
      if (r.op == OP_READ) begin
         sum = shared_count;
         for (int i = 0; i < NUM_CLIENTS; i++)
            sum = sum + client_count[i];
         res.accepted = 1'b1;
         res.total = sum;
      end else if (c >= NUM_CLIENTS) begin
         res.accepted = 1'b0;
      end else if (client_budget[c] - client_count[c] >= r.delta) begin
         client_count[c] = client_count[c] + r.delta;
         res.accepted = 1'b1;
      end else begin
         // slow path: return the local share, then take a fresh one
         shared_count = shared_count + client_count[c];
         client_count[c] = '0;
         shared_reserve = shared_reserve - client_budget[c];
         client_budget[c] = '0;
         if (spare_room() < r.delta) begin
            res.accepted = 1'b0;
         end else begin
            shared_count = shared_count + r.delta;
            divisor = (online_reg == 3'd0) ? 32'd1 : {29'd0, online_reg};
            grant = spare_room() / divisor;
            client_budget[c] = grant;
            shared_reserve = shared_reserve + grant;
            prefill = grant >> 1;
            if (prefill > shared_count)
               prefill = shared_count;
            client_count[c] = prefill;
            shared_count = shared_count - prefill;
            res.accepted = 1'b1;
         end
      end
      return res;
   endfunction

   initial begin
      failures = 0;
      pending = 0;
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         limit_reg = GLOBAL_LIMIT_RESET;
         online_reg = CLIENTS_ONLINE_RESET;
         for (int i = 0; i < NUM_CLIENTS; i++) begin
            client_count[i] = '0;
            client_budget[i] = '0;
         end
         shared_count = '0;
         shared_reserve = '0;
         due_rsp.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_GLOBAL_LIMIT)
               limit_reg = csr_pwdata[31:0];
            else
               online_reg = csr_pwdata[2:0];
         end
         if (rsp_valid && rsp_ready) begin
            if (due_rsp.size() == 0) begin
               $error("rsp: no item outstanding, got accepted %0d total %0h",
                  rsp_payload.accepted, rsp_payload.total);
               failures++;
            end else begin
               want = due_rsp.pop_front();
               if (rsp_payload.accepted !== want.accepted) begin
                  $error("accepted: expected %0d, got %0d",
                     want.accepted, rsp_payload.accepted);
                  failures++;
               end
               if (rsp_payload.total !== want.total) begin
                  $error("total: expected %0h, got %0h", want.total, rsp_payload.total);
                  failures++;
               end
            end
         end
         if (req_valid && req_ready)
            due_rsp.push_back(counter_step(req_payload));
      end
      pending <= due_rsp.size();
   end

endmodule

// ----- bench/approximate_limit_counter_top_tb.sv -----
// Testbench top for the limit counter: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module approximate_limit_counter_top_tb;
   import alc_pkg::*;
   import alc_tb_pkg::*;

   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int PHASE_ITEMS = 225;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   req_type               req_payload;
   logic                  rsp_valid;
   logic                  rsp_ready;
   rsp_type               rsp_payload;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    failures;
   int                    pending;
   int                    cycles;
   bit                    idling;
   bit                    req_held;

   approximate_limit_counter_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   approximate_limit_counter_checker chk (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_pready  (csr_pready),
      .failures    (failures),
      .pending     (pending)
   );

   initial clock = 1'b0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial cycles = 0;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("approximate_limit_counter_top: mismatch");
         $finish;
      end
   end

   // response side: random stall before each item while idling is set
   initial begin
      int n;
      rsp_ready = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         n = idling ? $urandom_range(0, 6) : 0;
         if (n > 0) begin
            rsp_ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   function automatic req_type pack_req(logic op, logic [1:0] client, logic [31:0] delta);
      req_type r;
      r.op = op;
      r.client = client;
      r.delta = delta;
      return r;
   endfunction

   task automatic drop_req();
      if (req_held) begin
         req_valid <= 1'b0;
         req_held = 1'b0;
      end
   endtask

   task automatic push_req(req_type r);
      int gap;
      gap = idling ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
         drop_req();
         repeat (gap) @(negedge clock);
      end
      req_payload <= r;
      req_valid <= 1'b1;
      req_held = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   task automatic drain();
      drop_req();
      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic csr_write(logic idx, logic [31:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(logic [31:0] limit, logic [2:0] online);
      drain();
      csr_write(REG_GLOBAL_LIMIT, limit);
      csr_write(REG_CLIENTS_ONLINE, {29'd0, online});
   endtask

   // mostly adds sized against the current limit, some reads and wild deltas
   function automatic req_type random_req(logic [31:0] limit);
      int          pick;
      logic [31:0] delta;
      pick = $urandom_range(0, 99);
      if (pick < 10)
         delta = $urandom_range(0, 255);
      else if (pick < 45)
         delta = $urandom_range(0, limit >> 8);
      else if (pick < 70)
         delta = $urandom_range(0, limit >> 4);
      else if (pick < 82)
         delta = $urandom();
      else if (pick < 86)
         delta = 32'hFFFF_FFFF;
      else
         delta = 32'd0;
      if ($urandom_range(0, 3) == 0)
         return pack_req(OP_READ, 2'($urandom_range(0, 3)), $urandom());
      return pack_req(OP_ADD, 2'($urandom_range(0, 3)), delta);
   endfunction

   initial begin
      logic [31:0] limits [8];
      logic [2:0]  onlines [8];
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      req_held = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      idling = 1'b1;
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // defaults from reset
      push_req(pack_req(OP_READ, 2'd0, 32'd0));
      push_req(pack_req(OP_ADD, 2'd0, 32'd0));
      push_req(pack_req(OP_ADD, 2'd0, 32'd1));
      push_req(pack_req(OP_ADD, 2'd0, 32'd5));
      push_req(pack_req(OP_ADD, 2'd1, 32'hFFFF_FFFF));
      push_req(pack_req(OP_ADD, 2'd2, 32'h7FFF_FFFF));
      push_req(pack_req(OP_ADD, 2'd3, 32'd100));
      push_req(pack_req(OP_READ, 2'd3, 32'hFFFF_FFFF));
      push_req(pack_req(OP_ADD, 2'd1, 32'h4000_0000));
      push_req(pack_req(OP_READ, 2'd1, 32'd0));
      // no headroom, no clients online
      configure(32'd0, 3'd0);
      push_req(pack_req(OP_ADD, 2'd0, 32'd1));
      push_req(pack_req(OP_ADD, 2'd2, 32'hFFFF_FFFF));
      push_req(pack_req(OP_ADD, 2'd3, 32'd0));
      push_req(pack_req(OP_READ, 2'd2, 32'd0));
      configure(32'hFFFF_FFFF, 3'd7);
      push_req(pack_req(OP_ADD, 2'd0, 32'hFFFF_FFFF));
      push_req(pack_req(OP_ADD, 2'd1, 32'h0000_1000));
      push_req(pack_req(OP_ADD, 2'd2, 32'h8000_0000));
      push_req(pack_req(OP_READ, 2'd0, 32'd0));
      push_req(pack_req(OP_ADD, 2'd3, 32'd1));
      push_req(pack_req(OP_READ, 2'd3, 32'd0));
      // limit well below current usage
      configure(32'h0000_0100, 3'd1);
      push_req(pack_req(OP_ADD, 2'd0, 32'h0001_0000));
      push_req(pack_req(OP_ADD, 2'd1, 32'd1));
      push_req(pack_req(OP_READ, 2'd1, 32'd0));

      limits = '{32'hFFFF_FFFF, 32'h0000_1000, 32'd0, 32'hFFFF_FFFF,
                 $urandom(), 32'h0010_0000, 32'hFFFF_FFFF, $urandom()};
      onlines = '{3'd1, 3'd4, 3'd0, 3'd7,
                  3'($urandom_range(0, 7)), 3'd2, 3'd3, 3'($urandom_range(0, 7))};
      for (int p = 0; p < 8; p++) begin
         configure(limits[p], onlines[p]);
         idling = (p % 3 != 1);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 1 && k == PHASE_ITEMS / 2)
               drain();
            push_req(random_req(limits[p]));
         end
      end

      drop_req();
      while (pending != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      if (failures == 0)
         $display("approximate_limit_counter_top: match");
      else
         $display("approximate_limit_counter_top: mismatch");
      $finish;
   end

endmodule
